// ----- hw/rtl/unix_time_to_calendar_assert.svh -----
// Assertion macros shared by the calendar converter RTL.
// Depends on the asserting module having signals named clk and rst_n.
`ifndef UNIX_TIME_TO_CALENDAR_ASSERT_SVH
`define UNIX_TIME_TO_CALENDAR_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define UTCAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define UTCAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/utcal_pkg.sv -----
// Types, reciprocal constants and the month table of the calendar converter.
// Used by every module of the block; depends on nothing.
package utcal_pkg;

  localparam int unsigned NSTG = 9;

  typedef logic [NSTG-1:0] stage_en_t;
  typedef logic [15:0] days_t;
  typedef logic [16:0] sod_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] weekday;
  } tod_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [15:0] DAY_RECIP    = 16'd49710;
  localparam logic [14:0] RECIP_15     = 15'd17477;
  localparam logic [16:0] RECIP_7      = 17'd74899;
  localparam logic [15:0] RECIP_365    = 16'd45965;
  localparam logic [12:0] RECIP_153    = 13'd6854;

  localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
  localparam logic [19:0] ERA4_START   = 20'd584388;
  localparam logic [19:0] ERA5_START   = 20'd730485;

  localparam logic [17:0] CENT_DAYS    = 18'd36524;
  localparam logic [17:0] ERA_LAST_DAY = 18'd146096;

  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ----- hw/rtl/unix_time_to_calendar.sv -----
// Converts a 32-bit Unix time in seconds into time of day, date and weekday.
// Top level; depends on utcal_pkg, utcal_split, utcal_clock, utcal_date and
// unix_time_to_calendar_assert.svh.
//
// Usage: the input channel carries one word, in_unix_seconds, under
// in_valid and in_stall. The output channel carries one word per input word,
// in the same order, under out_valid and out_stall. An input of zero means
// that no host time is known yet; its word has out_time_valid low and every
// other field zero. A nonzero input gives the date and time in UTC.
// The datapath is nine register stages. A new word can be accepted in every
// cycle that in_stall is low, so throughput is one conversion per cycle while
// the output is not stalled. Each stage loads when it is empty or when the
// stage after it moves, so a stalled receiver holds the last word steady while
// the earlier stages keep filling; in_stall rises only once all nine stages
// hold words. Reset clears every stage's valid bit; data registers are not
// reset.
`include "unix_time_to_calendar_assert.svh"

module unix_time_to_calendar
  import utcal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_unix_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_time_valid,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [2:0]  out_weekday
);

  localparam int unsigned LAST = NSTG - 1;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] tv_r;
  stage_en_t       adv;

  days_t days;
  sod_t  sod;
  tod_t  tod;
  date_t date;
  logic  tv;

  always_comb begin
    adv[LAST] = !v_r[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k <= LAST; k++) begin
      if (adv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tv_r[0] <= in_unix_seconds != 32'd0;
    end
    for (int k = 1; k <= LAST; k++) begin
      if (adv[k]) begin
        tv_r[k] <= tv_r[k-1];
      end
    end
  end

  utcal_split u_split (
    .clk  (clk),
    .adv  (adv),
    .secs (in_unix_seconds),
    .days (days),
    .sod  (sod)
  );

  utcal_clock u_clock (
    .clk  (clk),
    .adv  (adv),
    .days (days),
    .sod  (sod),
    .tod  (tod)
  );

  utcal_date u_date (
    .clk  (clk),
    .adv  (adv),
    .days (days),
    .date (date)
  );

  assign tv             = tv_r[LAST];
  assign in_stall       = !adv[0];
  assign out_valid      = v_r[LAST];
  assign out_time_valid = tv;
  assign out_hour       = tv ? tod.hour : '0;
  assign out_minute     = tv ? tod.minute : '0;
  assign out_weekday    = tv ? tod.weekday : '0;
  assign out_year       = tv ? date.year : '0;
  assign out_month      = tv ? date.month : '0;
  assign out_day        = tv ? date.day : '0;

  `UTCAL_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "Output valid right after reset.")
  `UTCAL_ASSERT(a_stall_full, in_stall |-> ((&v_r) && out_stall), "Input stalled with room left.")
  `UTCAL_ASSERT(a_no_time_zero, (out_valid && !out_time_valid) |-> ((out_year == 12'd0) && (out_month == 4'd0) && (out_day == 5'd0) && (out_hour == 5'd0) && (out_minute == 6'd0) && (out_weekday == 3'd0)), "Fields not zero without a time.")
  `UTCAL_ASSERT(a_date_range, (out_valid && out_time_valid) |-> ((out_year >= 12'd1970) && (out_year <= 12'd2106) && (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1)), "Date out of range.")
  `UTCAL_ASSERT(a_clock_range, (out_valid && out_time_valid) |-> ((out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_weekday <= 3'd6)), "Time of day out of range.")

endmodule

// ----- hw/rtl/utcal_split.sv -----
// Splits the seconds count into whole days and the second of the day.
// Stages 0 to 2 of the pipeline; depends on utcal_pkg.
module utcal_split
  import utcal_pkg::*;
(
  input  logic        clk,
  input  stage_en_t   adv,
  input  logic [31:0] secs,
  output days_t       days,
  output sod_t        sod
);

  logic [40:0] prod_r;
  logic [40:0] prod_nxt;
  logic [31:0] secs_r;
  logic [15:0] quo_r;
  logic [15:0] quo_nxt;
  logic [17:0] rem_r;
  logic [17:0] rem_nxt;
  logic [32:0] rem_full;
  logic        rem_ge;
  days_t       days_r;
  days_t       days_nxt;
  sod_t        sod_r;
  sod_t        sod_nxt;

  assign prod_nxt = 41'(secs[31:7]) * 41'(DAY_RECIP);

  // The estimate is the true quotient or one below it.
  assign quo_nxt  = prod_r[40:25];
  assign rem_full = {1'b0, secs_r} - 33'(quo_nxt) * 33'(SECS_PER_DAY);
  assign rem_nxt  = rem_full[17:0];

  assign rem_ge   = rem_r >= 18'(SECS_PER_DAY);
  assign days_nxt = quo_r + 16'(rem_ge);
  assign sod_nxt  = rem_ge ? 17'(rem_r - 18'(SECS_PER_DAY)) : rem_r[16:0];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod_r <= prod_nxt;
      secs_r <= secs;
    end
    if (adv[1]) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (adv[2]) begin
      days_r <= days_nxt;
      sod_r  <= sod_nxt;
    end
  end

  assign days = days_r;
  assign sod  = sod_r;

endmodule

// ----- hw/rtl/utcal_clock.sv -----
// Hour, minute and weekday from the day count and second of the day.
// Stages 3 to 8 of the pipeline; depends on utcal_pkg.
module utcal_clock
  import utcal_pkg::*;
(
  input  logic      clk,
  input  stage_en_t adv,
  input  days_t     days,
  input  sod_t      sod,
  output tod_t      tod
);

  localparam int unsigned LAST = NSTG - 1;

  logic [29:0] mtp_r;
  logic [29:0] mtp_nxt;
  logic [16:0] w_r;
  logic [16:0] w_nxt;
  logic [33:0] wdp_r;
  logic [33:0] wdp_nxt;

  logic [10:0] mt_nxt;
  logic [10:0] mt_r;
  logic [23:0] hp_r;
  logic [23:0] hp_nxt;
  logic [12:0] q7;
  logic [16:0] wd_full;
  logic [2:0]  wd_r;
  logic [2:0]  wd_nxt;

  logic [4:0]  hr;
  logic [10:0] mn_full;
  tod_t        tod_nxt;
  tod_t        tod_r [5:LAST];

  assign mtp_nxt = 30'(sod[16:2]) * 30'(RECIP_15);
  assign w_nxt   = 17'(days) + 17'd4;
  assign wdp_nxt = 34'(w_nxt) * 34'(RECIP_7);

  assign mt_nxt  = mtp_r[28:18];
  assign hp_nxt  = 24'(mt_nxt[10:2]) * 24'(RECIP_15);
  assign q7      = wdp_r[31:19];
  assign wd_full = w_r - 17'(q7) * 17'd7;
  assign wd_nxt  = wd_full[2:0];

  assign hr      = hp_r[22:18];
  assign mn_full = mt_r - 11'(hr) * 11'd60;
  assign tod_nxt = '{hour: hr, minute: mn_full[5:0], weekday: wd_r};

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      mtp_r <= mtp_nxt;
      w_r   <= w_nxt;
      wdp_r <= wdp_nxt;
    end
    if (adv[4]) begin
      mt_r <= mt_nxt;
      hp_r <= hp_nxt;
      wd_r <= wd_nxt;
    end
    if (adv[5]) begin
      tod_r[5] <= tod_nxt;
    end
    for (int k = 6; k <= LAST; k++) begin
      if (adv[k]) begin
        tod_r[k] <= tod_r[k-1];
      end
    end
  end

  assign tod = tod_r[LAST];

endmodule

// ----- hw/rtl/utcal_date.sv -----
// Proleptic Gregorian year, month and day from the day count.
// Stages 3 to 8 of the pipeline, era and day-of-era method; depends on utcal_pkg.
module utcal_date
  import utcal_pkg::*;
(
  input  logic      clk,
  input  stage_en_t adv,
  input  days_t     days,
  output date_t     date
);

  logic [19:0] shifted;
  logic        era3_nxt;
  logic [17:0] doe3_nxt;
  logic        era3_r;
  logic [17:0] doe3_r;

  logic [31:0] pa_nxt;
  logic [2:0]  cen_nxt;
  logic        lastd_nxt;
  logic [31:0] pa_r;
  logic [2:0]  cen_r;
  logic        lastd_r;
  logic        era4_r;
  logic [17:0] doe4_r;

  logic [17:0] t_sum;
  logic [33:0] pt_nxt;
  logic [33:0] pt_r;
  logic        era5_r;
  logic [17:0] doe5_r;

  logic [8:0]  yoe_nxt;
  logic [8:0]  c100;
  logic [17:0] ysum;
  logic [17:0] doy_full;
  logic [8:0]  doy_nxt;
  logic [8:0]  yoe6_r;
  logic [8:0]  doy6_r;
  logic        era6_r;

  logic [10:0] v;
  logic [23:0] pm_nxt;
  logic [23:0] pm_r;
  logic [8:0]  yoe7_r;
  logic [8:0]  doy7_r;
  logic        era7_r;

  logic [3:0]  mp;
  logic [8:0]  dfull;
  logic [3:0]  mon;
  date_t       date_nxt;
  date_t       date_r;

  assign shifted   = 20'(days) + EPOCH_SHIFT;
  assign era3_nxt  = shifted >= ERA5_START;
  assign doe3_nxt  = 18'(shifted - (era3_nxt ? ERA5_START : ERA4_START));

  assign pa_nxt    = 32'(doe3_r[17:2]) * 32'(RECIP_365);
  assign cen_nxt   = 3'(doe3_r >= CENT_DAYS) + 3'(doe3_r >= 18'(2 * CENT_DAYS))
                   + 3'(doe3_r >= 18'(3 * CENT_DAYS)) + 3'(doe3_r >= ERA_LAST_DAY);
  assign lastd_nxt = doe3_r == ERA_LAST_DAY;

  assign t_sum     = doe4_r - 18'(pa_r[30:24]) + 18'(cen_r) - 18'(lastd_r);
  assign pt_nxt    = 34'(t_sum) * 34'(RECIP_365);

  assign yoe_nxt   = pt_r[32:24];
  assign c100      = 9'(yoe_nxt >= 9'd100) + 9'(yoe_nxt >= 9'd200) + 9'(yoe_nxt >= 9'd300);
  assign ysum      = 18'(yoe_nxt) * 18'd365 + 18'(yoe_nxt[8:2]) - 18'(c100);
  assign doy_full  = doe5_r - ysum;
  assign doy_nxt   = doy_full[8:0];

  assign v         = 11'(doy6_r) * 11'd5 + 11'd2;
  assign pm_nxt    = 24'(v) * 24'(RECIP_153);

  // Months are counted from March, so January and February end the year.
  assign mp        = pm_r[23:20];
  assign dfull     = doy7_r - month_start(mp) + 9'd1;
  assign mon       = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
  assign date_nxt  = '{
    year:  12'(yoe7_r) + (era7_r ? 12'd2000 : 12'd1600) + 12'(mon <= 4'd2),
    month: mon,
    day:   dfull[4:0]
  };

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      era3_r <= era3_nxt;
      doe3_r <= doe3_nxt;
    end
    if (adv[4]) begin
      pa_r    <= pa_nxt;
      cen_r   <= cen_nxt;
      lastd_r <= lastd_nxt;
      era4_r  <= era3_r;
      doe4_r  <= doe3_r;
    end
    if (adv[5]) begin
      pt_r   <= pt_nxt;
      era5_r <= era4_r;
      doe5_r <= doe4_r;
    end
    if (adv[6]) begin
      yoe6_r <= yoe_nxt;
      doy6_r <= doy_nxt;
      era6_r <= era5_r;
    end
    if (adv[7]) begin
      pm_r   <= pm_nxt;
      yoe7_r <= yoe6_r;
      doy7_r <= doy6_r;
      era7_r <= era6_r;
    end
    if (adv[8]) begin
      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

// ----- dv/tb_unix_time_to_calendar.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for unix_time_to_calendar: random and corner Unix times are
// converted by an in-bench calendar predictor and compared word by word with the block's
// results. Depends only on the unix_time_to_calendar RTL and its package.
module tb_unix_time_to_calendar;

  localparam int unsigned NUM_RANDOM  = 576;
  localparam int unsigned MAX_CYCLES  = 200000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned DRAIN_WAIT  = 24;
  localparam int unsigned DAYS_MAX    = 49710;

  typedef struct packed {
    logic        time_valid;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
  } civil_word_t;

  class calendar_checker;
    civil_word_t expected_dates[$];
    int unsigned fail_count;
    int unsigned seen_words;
    int unsigned no_time_words;

    function civil_word_t civil_time_of(logic [31:0] secs);
      civil_word_t w;
      int unsigned days, sod, shifted, era, doe, yoe, doy, mp, mon;
      w = '0;
      if (secs != 0) begin
        days = secs / 86400;
        sod = secs % 86400;
        shifted = days + 719468;
        era = shifted / 146097;
        doe = shifted - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        w.time_valid = 1'b1;
        w.hour = 5'(sod / 3600);
        w.minute = 6'((sod / 60) % 60);
        w.year = 12'(yoe + era * 400 + ((mon <= 2) ? 1 : 0));
        w.month = 4'(mon);
        w.day = 5'(doy - (153 * mp + 2) / 5 + 1);
        w.weekday = 3'((days + 4) % 7);
      end
      return w;
    endfunction

    task flag_mismatch(string what, int unsigned got, int unsigned want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
    endtask

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    task note_seconds(logic [31:0] secs);
      expected_dates.push_back(civil_time_of(secs));
      if (secs == 0) no_time_words++;
    endtask

    task check_date(civil_word_t got);
      civil_word_t want;
      seen_words++;
      if (expected_dates.size() == 0) begin
        flag_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_dates.pop_front();
        if (got.time_valid !== want.time_valid)
          flag_mismatch("time_valid", got.time_valid, want.time_valid);
        if (got.hour !== want.hour) flag_mismatch("hour", got.hour, want.hour);
        if (got.minute !== want.minute) flag_mismatch("minute", got.minute, want.minute);
        if (got.year !== want.year) flag_mismatch("year", got.year, want.year);
        if (got.month !== want.month) flag_mismatch("month", got.month, want.month);
        if (got.day !== want.day) flag_mismatch("day", got.day, want.day);
        if (got.weekday !== want.weekday)
          flag_mismatch("weekday", got.weekday, want.weekday);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_unix_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_time_valid;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [2:0]  out_weekday;

  calendar_checker sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     input_stall_cycles = 0;

  bit [31:0] corner_secs [24] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd68169600, 32'd68256000, 32'd946684799, 32'd946684800,
    32'd951782400, 32'd951868800, 32'd4102444799, 32'd4107542399,
    32'd4107542400, 32'h7FFFFFFF, 32'h80000000, 32'h55555555,
    32'hAAAAAAAA, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'd0
  };

  unix_time_to_calendar i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_unix_seconds (in_unix_seconds),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_time_valid  (out_time_valid),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_weekday     (out_weekday)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb_unix_time_to_calendar: FAIL");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && in_stall) input_stall_cycles <= input_stall_cycles + 1;
      if (in_valid && !in_stall) sb.note_seconds(in_unix_seconds);
      if (out_valid && !out_stall)
        sb.check_date({out_time_valid, out_hour, out_minute, out_year, out_month,
                       out_day, out_weekday});
    end
  end

  function automatic logic [31:0] pick_seconds();
    logic [31:0] day_start;
    day_start = 32'($urandom_range(0, DAYS_MAX)) * 32'd86400;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return day_start;
      2: return day_start - 32'd1;
      3: return day_start + 32'($urandom_range(86340, 86399));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(logic [31:0] secs, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_unix_seconds <= secs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed_times();
    bit quiet;
    int unsigned pause_at;
    pause_at = $urandom_range(200, 400);
    quiet = 1'b0;
    foreach (corner_secs[i]) send_word(corner_secs[i], $urandom_range(0, 16));
    for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      send_word(pick_seconds(), quiet ? 0 : $urandom_range(0, 16));
    end
    in_valid <= 1'b0;
  endtask

  task automatic take_dates();
    int unsigned taken, hold;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    forever begin
      if (taken % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      hold = quiet ? 0 : $urandom_range(0, 16);
      if (taken == 150) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      take_dates();
    join_none
    feed_times();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Checked %0d calendar words (%0d without host time), including corner dates;",
             sb.seen_words, sb.no_time_words);
    $display("input was back-pressured for %0d cycles in all, the long output hold-off included.",
             input_stall_cycles);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("tb_unix_time_to_calendar: PASS");
    end else begin
      $display("tb_unix_time_to_calendar: FAIL");
    end
    $finish;
  end

endmodule
